### sv/modmv_pkg.sv
package modmv_pkg;

   localparam int MAX_DIM   = 16;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int SIZE_W    = 5;
   localparam int VAL_W     = 16;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int DIV_STEPS = PROD_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam logic [1:0] OP_MAT_WR  = 2'd0;
   localparam logic [1:0] OP_VEC_WR  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_SIZE    = 1'b1;

   localparam logic [VAL_W-1:0]  MODULUS_RESET = 16'd3;
   localparam logic [SIZE_W-1:0] SIZE_RESET    = 5'd16;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [15:0] value;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  row_index;
      logic [15:0] result;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic             mat_wr;
      logic             vec_wr;
      logic             rd;
      logic             mul;
      logic             div;
      logic             acc;
      logic             emit;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } cmd_type;

   // one restoring step of the remainder, rem below m on entry
   function automatic logic [VAL_W-1:0] rem_step(input logic [VAL_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [VAL_W-1:0] m);
      logic [VAL_W:0] r;
      r = {rem, bit_in};
      if (r >= {1'b0, m}) begin
         r = r - {1'b0, m};
      end
      return r[VAL_W-1:0];
   endfunction

endpackage

### sv/modular_matrix_vector_product.sv
// channel   ports                                   direction   handshake
// item in   start, busy, req_item                   in          start && !busy
// result    rsp_valid, rsp_item                     out         rsp_valid, one cycle
// config    csr_wr_en, csr_index, csr_wdata         in          csr_wr_en
//
// loads write when accepted; compute: READ, MUL, DIV, ACC per element, EMIT per row
// each element: one memory read, one 16x16 multiply, and 2-bit remainder steps
// synchronous active-high reset; stores hold garbage until written
// the receiver cannot stall: each result shows for exactly one cycle
module modular_matrix_vector_product (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  modmv_pkg::req_item_type        req_item,
   output logic                           rsp_valid,
   output modmv_pkg::rsp_item_type        rsp_item,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [15:0]                    csr_wdata
);
   import modmv_pkg::*;

   cmd_type cmd;

   modmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   modmv_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### sv/modmv_ctrl.sv
module modmv_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  modmv_pkg::req_item_type        req_item,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [15:0]                    csr_wdata,
   output modmv_pkg::cmd_type             cmd
);
   import modmv_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  nlast_ff, nlast_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] n_eff;
   logic              accept;
   logic              row_ok, col_ok;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign n_eff  = (size_ff > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_ff;
   assign row_ok = ({1'b0, req_item.row} < 5'(MAX_DIM));
   assign col_ok = ({1'b0, req_item.col} < 5'(MAX_DIM));

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      nlast_in = nlast_ff;
      dcnt_in  = dcnt_ff;
      size_in  = size_ff;
      cmd        = '0;
      cmd.row    = i_ff;
      cmd.col    = j_ff;
      cmd.last   = (i_ff == nlast_ff);
      if (csr_wr_en && csr_index == CSR_SIZE) begin
         size_in = csr_wdata[SIZE_W-1:0];
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.mat_wr = (req_item.operation == OP_MAT_WR) && row_ok && col_ok;
               cmd.vec_wr = (req_item.operation == OP_VEC_WR) && col_ok;
               if (req_item.operation == OP_COMPUTE && n_eff != '0) begin
                  i_in     = '0;
                  j_in     = '0;
                  nlast_in = IDX_W'(n_eff - 1'b1);
                  cmd.acc  = 1'b0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (j_ff == nlast_ff) begin
               state_in = S_EMIT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            j_in     = '0;
            if (i_ff == nlast_ff) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= SIZE_RESET;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      nlast_ff <= nlast_in;
      dcnt_ff  <= dcnt_in;
   end

   a_emit_at_row_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> j_ff == nlast_ff)
      else $error("row emitted before all columns summed");

   a_acc_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC |-> $past(state_ff) == S_DIV)
      else $error("accumulate without finished reduction");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> i_ff <= nlast_ff && j_ff <= nlast_ff)
      else $error("row or column index beyond size");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> state_ff == S_IDLE)
      else $error("run continues after last row");

endmodule

### sv/modmv_dp.sv
module modmv_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  modmv_pkg::req_item_type        req_item,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [15:0]                    csr_wdata,
   input  modmv_pkg::cmd_type             cmd,
   output logic                           rsp_valid,
   output modmv_pkg::rsp_item_type        rsp_item
);
   import modmv_pkg::*;

   logic [VAL_W-1:0]  mat_mem [MAX_DIM*MAX_DIM];
   logic [VAL_W-1:0]  vec_mem [MAX_DIM];
   logic [VAL_W-1:0]  mat_q_ff, vec_q_ff;
   logic [PROD_W-1:0] dvd_ff, dvd_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  acc_ff, acc_in;
   logic [VAL_W-1:0]  modulus_ff, modulus_in;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   logic [VAL_W:0]    acc_sum;

   assign modulus_in = (csr_wr_en && csr_index == CSR_MODULUS) ? csr_wdata : modulus_ff;

   always_ff @(posedge clock) begin
      if (cmd.mat_wr) begin
         mat_mem[{req_item.row[IDX_W-1:0], req_item.col[IDX_W-1:0]}] <= req_item.value;
      end
      if (cmd.rd) begin
         mat_q_ff <= mat_mem[{cmd.row, cmd.col}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vec_wr) begin
         vec_mem[req_item.col[IDX_W-1:0]] <= req_item.value;
      end
      if (cmd.rd) begin
         vec_q_ff <= vec_mem[cmd.col];
      end
   end

   assign acc_sum = {1'b0, acc_ff} + {1'b0, rem_ff};

   always_comb begin
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      rsp_item_in = rsp_item_ff;
      if (cmd.mul) begin
         dvd_in = mat_q_ff * vec_q_ff;
         rem_in = '0;
      end
      if (cmd.div) begin
         rem_in = rem_step(rem_step(rem_ff, dvd_ff[PROD_W-1], modulus_ff),
                           dvd_ff[PROD_W-2], modulus_ff);
         dvd_in = {dvd_ff[PROD_W-3:0], 2'b00};
      end
      if (cmd.acc) begin
         acc_in = (acc_sum >= {1'b0, modulus_ff}) ? VAL_W'(acc_sum - {1'b0, modulus_ff})
                                                  : acc_sum[VAL_W-1:0];
      end
      if (cmd.emit) begin
         acc_in                = '0;
         rsp_item_in.row_index = 4'(cmd.row);
         rsp_item_in.result    = (modulus_ff == '0) ? '0 : acc_ff;
         rsp_item_in.last      = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= cmd.emit;
         acc_ff       <= acc_in;
      end
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.acc) && modulus_ff != '0 |-> acc_ff < modulus_ff)
      else $error("row sum not reduced");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && modulus_ff != '0 |-> rsp_item.result < modulus_ff)
      else $error("result not below modulus");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule
